// File: rtl/fddr_pkg.sv
// ----------------------------------------------------------------------------
// fddr_pkg
// Shared types and constants of the frame difference dirty rectangle block.
// ----------------------------------------------------------------------------
package fddr_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 768;

  // entries of the queue between front and back
  localparam int Q_DEPTH = 4;

  // register indexes on the configuration port
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam logic [10:0] FRAME_WIDTH_RST  = 11'd1024;
  localparam logic [9:0]  FRAME_HEIGHT_RST = 10'd768;

  typedef struct packed {
    logic full;
    logic empty;
  } fddr_q_status_t;

endpackage

// File: rtl/frame_diff_dirty_rect.sv
// ----------------------------------------------------------------------------
// frame_diff_dirty_rect
// Framebuffer damage bounding box: compares each pixel with a shadow copy of
// the previous frame and reports the changed region once per frame.
// ----------------------------------------------------------------------------
// throughput: one pixel item per cycle while in_stall is low, set by the single
// read and single write port of the shadow store in the back stage
// result: registered once the last pixel has passed the queue and back stage
// reset: the shadow store is cleared one entry a cycle, all MAX_WIDTH*MAX_HEIGHT
// entries with in_stall high; configuration writes are taken meanwhile
// ----------------------------------------------------------------------------
module frame_diff_dirty_rect
  import fddr_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_pixel_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_dirty_found,
  output logic [9:0]  out_x_min,
  output logic [9:0]  out_y_min,
  output logic [10:0] out_x_end,
  output logic [9:0]  out_y_end,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int QW    = 32 + AW + XW + YW + 1;

  logic [10:0]    frame_width_r;
  logic [9:0]     frame_height_r;
  logic           cfg_wr;

  fddr_q_status_t q_status;
  logic           q_push, q_pop;
  logic [QW-1:0]  q_wdata, q_rdata;
  logic           clearing;

  logic [31:0]    f_pix, h_pix;
  logic [AW-1:0]  f_addr, h_addr;
  logic [XW-1:0]  f_col, h_col;
  logic [YW-1:0]  f_row, h_row;
  logic           f_fe, h_fe;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_FRAME_WIDTH:  frame_width_r  <= pwdata[10:0];
        REG_FRAME_HEIGHT: frame_height_r <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_FRAME_WIDTH:  prdata = 32'(frame_width_r);
      REG_FRAME_HEIGHT: prdata = 32'(frame_height_r);
      default:          prdata = 32'd0;
    endcase
  end

  fddr_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pixel_value (in_pixel_value),
    .frame_width    (frame_width_r),
    .frame_height   (frame_height_r),
    .blocked        (clearing),
    .q_status       (q_status),
    .q_push         (q_push),
    .q_pix          (f_pix),
    .q_addr         (f_addr),
    .q_col          (f_col),
    .q_row          (f_row),
    .q_frame_end    (f_fe)
  );

  assign q_wdata = {f_pix, f_addr, f_col, f_row, f_fe};
  assign {h_pix, h_addr, h_col, h_row, h_fe} = q_rdata;

  fddr_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .pop    (q_pop),
    .rdata  (q_rdata),
    .status (q_status)
  );

  fddr_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_status        (q_status),
    .q_pix           (h_pix),
    .q_addr          (h_addr),
    .q_col           (h_col),
    .q_row           (h_row),
    .q_frame_end     (h_fe),
    .q_pop           (q_pop),
    .clearing        (clearing),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_dirty_found (out_dirty_found),
    .out_x_min       (out_x_min),
    .out_y_min       (out_y_min),
    .out_x_end       (out_x_end),
    .out_y_end       (out_y_end)
  );

endmodule

// File: rtl/fddr_front.sv
// ----------------------------------------------------------------------------
// fddr_front
// Accepts pixel items, tracks column and row, forms the shadow address and
// flags the last pixel of each frame, then pushes the item into the queue.
// ----------------------------------------------------------------------------
module fddr_front
  import fddr_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [31:0]    in_pixel_value,
  input  logic [10:0]    frame_width,
  input  logic [9:0]     frame_height,
  input  logic           blocked,
  input  fddr_q_status_t q_status,
  output logic           q_push,
  output logic [31:0]    q_pix,
  output logic [AW-1:0]  q_addr,
  output logic [XW-1:0]  q_col,
  output logic [YW-1:0]  q_row,
  output logic           q_frame_end
);

  localparam int WCW = (XW + 1 > 11) ? XW + 1 : 11;
  localparam int HCW = (YW + 1 > 10) ? YW + 1 : 10;

  logic [XW-1:0]  col_r, col_nxt;
  logic [YW-1:0]  row_r, row_nxt;
  logic [AW-1:0]  base_r, base_nxt;
  logic [WCW-1:0] w_ext, w_lim;
  logic [HCW-1:0] h_ext, h_lim;
  logic           line_end;
  logic           frame_end;
  logic           in_fire;

  assign in_stall = blocked || q_status.full;
  assign in_fire  = in_valid && !in_stall;

  // zero acts as one, oversize acts as the maximum
  assign w_ext = WCW'(frame_width);
  assign h_ext = HCW'(frame_height);
  assign w_lim = (w_ext == '0) ? WCW'(1) :
                 (w_ext > WCW'(MAX_WIDTH)) ? WCW'(MAX_WIDTH) : w_ext;
  assign h_lim = (h_ext == '0) ? HCW'(1) :
                 (h_ext > HCW'(MAX_HEIGHT)) ? HCW'(MAX_HEIGHT) : h_ext;

  assign line_end  = (WCW'(col_r) + WCW'(1)) >= w_lim;
  assign frame_end = line_end && ((HCW'(row_r) + HCW'(1)) >= h_lim);

  assign q_push      = in_fire;
  assign q_pix       = in_pixel_value;
  assign q_addr      = base_r + AW'(col_r);
  assign q_col       = col_r;
  assign q_row       = row_r;
  assign q_frame_end = frame_end;

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    base_nxt = base_r;
    if (in_fire) begin
      if (!line_end) begin
        col_nxt = col_r + XW'(1);
      end else if (!frame_end) begin
        col_nxt  = '0;
        row_nxt  = row_r + YW'(1);
        base_nxt = base_r + AW'(MAX_WIDTH);
      end else begin
        col_nxt  = '0;
        row_nxt  = '0;
        base_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      base_r <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      base_r <= base_nxt;
    end
  end

endmodule

// File: rtl/fddr_queue.sv
// ----------------------------------------------------------------------------
// fddr_queue
// Short first-in first-out queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module fddr_queue
  import fddr_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output fddr_q_status_t   status
);

  localparam int QAW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QCW = $clog2(Q_DEPTH + 1);

  logic [WIDTH-1:0] entry_r [Q_DEPTH];
  logic [QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]   count_r, count_nxt;

  assign rdata        = entry_r[rd_ptr_r];
  assign status.full  = (count_r == QCW'(Q_DEPTH));
  assign status.empty = (count_r == '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QAW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + QAW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QAW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + QAW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + QCW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// File: rtl/fddr_back.sv
// ----------------------------------------------------------------------------
// fddr_back
// Shadow frame store with read-compare-write, bounding box tracking and the
// per-frame result register. Clears the shadow store after reset.
// ----------------------------------------------------------------------------
module fddr_back
  import fddr_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  fddr_q_status_t q_status,
  input  logic [31:0]    q_pix,
  input  logic [AW-1:0]  q_addr,
  input  logic [XW-1:0]  q_col,
  input  logic [YW-1:0]  q_row,
  input  logic           q_frame_end,
  output logic           q_pop,
  output logic           clearing,
  output logic           out_valid,
  input  logic           out_stall,
  output logic           out_dirty_found,
  output logic [9:0]     out_x_min,
  output logic [9:0]     out_y_min,
  output logic [10:0]    out_x_end,
  output logic [9:0]     out_y_end
);

  logic [31:0]   shadow_mem [DEPTH];
  logic [31:0]   rdata_r;

  logic          clr_r, clr_nxt;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;

  logic          b_valid_r, b_valid_nxt;
  logic [31:0]   b_pix_r;
  logic [AW-1:0] b_addr_r;
  logic [XW-1:0] b_col_r;
  logic [YW-1:0] b_row_r;
  logic          b_fe_r;
  logic          fwd_hit_r;
  logic [31:0]   fwd_data_r;

  logic          any_r, any_upd;
  logic [XW-1:0] left_r, left_upd, right_r, right_upd;
  logic [YW-1:0] top_r, top_upd, bottom_r, bottom_upd;

  logic          out_valid_r, out_valid_nxt;
  logic          dirty_r;
  logic [9:0]    x_min_r, y_min_r, y_end_r;
  logic [10:0]   x_end_r;

  logic [31:0]   b_cur;
  logic          b_diff;
  logic          b_done;
  logic          a_fire;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;
  logic [XW:0]   right_inc;
  logic [YW:0]   bottom_inc;

  assign clearing = clr_r;

  // back stage finishes unless a frame result cannot be placed
  assign b_done = b_valid_r && (!b_fe_r || !out_valid_r || !out_stall);
  assign a_fire = !q_status.empty && (!b_valid_r || b_done);
  assign q_pop  = a_fire;

  assign b_cur  = fwd_hit_r ? fwd_data_r : rdata_r;
  assign b_diff = (b_cur != b_pix_r);

  assign mem_we    = clr_r || (b_done && b_diff);
  assign mem_waddr = clr_r ? clr_addr_r : b_addr_r;
  assign mem_wdata = clr_r ? 32'd0 : b_pix_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      shadow_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (a_fire) begin
      rdata_r <= shadow_mem[q_addr];
    end
  end

  // clearing pass over the shadow store
  always_comb begin
    clr_nxt      = clr_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_r) begin
      if (clr_addr_r == AW'(DEPTH - 1)) begin
        clr_nxt = 1'b0;
      end else begin
        clr_addr_nxt = clr_addr_r + AW'(1);
      end
    end
  end

  always_comb begin
    b_valid_nxt = b_valid_r;
    if (a_fire) begin
      b_valid_nxt = 1'b1;
    end else if (b_done) begin
      b_valid_nxt = 1'b0;
    end
  end

  // bounding box including the pixel in the back stage
  always_comb begin
    any_upd    = any_r;
    left_upd   = left_r;
    right_upd  = right_r;
    top_upd    = top_r;
    bottom_upd = bottom_r;
    if (b_diff) begin
      if (!any_r) begin
        any_upd    = 1'b1;
        left_upd   = b_col_r;
        right_upd  = b_col_r;
        top_upd    = b_row_r;
        bottom_upd = b_row_r;
      end else begin
        if (b_col_r < left_r)   left_upd   = b_col_r;
        if (b_col_r > right_r)  right_upd  = b_col_r;
        if (b_row_r < top_r)    top_upd    = b_row_r;
        if (b_row_r > bottom_r) bottom_upd = b_row_r;
      end
    end
  end

  assign right_inc  = (XW + 1)'(right_upd) + (XW + 1)'(1);
  assign bottom_inc = (YW + 1)'(bottom_upd) + (YW + 1)'(1);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (b_done && b_fe_r) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= 1'b1;
      clr_addr_r  <= '0;
      b_valid_r   <= 1'b0;
      fwd_hit_r   <= 1'b0;
      out_valid_r <= 1'b0;
      any_r       <= 1'b0;
      left_r      <= '1;
      right_r     <= '0;
      top_r       <= '1;
      bottom_r    <= '0;
    end else begin
      clr_r       <= clr_nxt;
      clr_addr_r  <= clr_addr_nxt;
      b_valid_r   <= b_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (a_fire) begin
        fwd_hit_r <= b_done && (b_addr_r == q_addr);
      end
      if (b_done) begin
        if (b_fe_r) begin
          any_r    <= 1'b0;
          left_r   <= '1;
          right_r  <= '0;
          top_r    <= '1;
          bottom_r <= '0;
        end else begin
          any_r    <= any_upd;
          left_r   <= left_upd;
          right_r  <= right_upd;
          top_r    <= top_upd;
          bottom_r <= bottom_upd;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (a_fire) begin
      b_pix_r    <= q_pix;
      b_addr_r   <= q_addr;
      b_col_r    <= q_col;
      b_row_r    <= q_row;
      b_fe_r     <= q_frame_end;
      fwd_data_r <= b_pix_r;
    end
    if (b_done && b_fe_r) begin
      dirty_r <= any_upd;
      x_min_r <= any_upd ? 10'(left_upd) : 10'd0;
      y_min_r <= any_upd ? 10'(top_upd) : 10'd0;
      x_end_r <= any_upd ? 11'(right_inc) : 11'd0;
      y_end_r <= any_upd ? 10'(bottom_inc) : 10'd0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_dirty_found = dirty_r;
  assign out_x_min       = x_min_r;
  assign out_y_min       = y_min_r;
  assign out_x_end       = x_end_r;
  assign out_y_end       = y_end_r;

endmodule
